// ===== rtl/ipv4ft_pkg.sv =====
// Shared types and constants for the IPv4 five-tuple extractor.
// Used by the front, queue and back modules, the top level and the checker.
// No dependencies.
package ipv4ft_pkg;

  localparam int unsigned OUT_TDATA_W = 128;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] IP_VERSION4  = 4'd4;
  localparam logic [3:0] MIN_IHL      = 4'd5;
  localparam logic [6:0] L4_SHORT_HDR = 7'd8;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Everything captured from one packet, handed from front to back.
  typedef struct packed {
    logic [15:0] cap_len;
    logic [3:0]  version;
    logic [3:0]  hdr_words;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [3:0]  tcp_off;
    logic        off_seen;
  } pkt_rec_t;

  // Queue occupancy flags seen by the top level and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/ipv4ft_front.sv =====
// Front end of the IPv4 five-tuple extractor: byte counter and header capture.
// Pushes one packet record per final byte. Depends on ipv4ft_pkg.
module ipv4ft_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_fire,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 push,
  output ipv4ft_pkg::pkt_rec_t push_rec
);
  import ipv4ft_pkg::*;

  localparam logic [15:0] IDX_LEN_HI = 16'd2;
  localparam logic [15:0] IDX_LEN_LO = 16'd3;
  localparam logic [15:0] IDX_PROTO  = 16'd9;
  localparam logic [15:0] IDX_SRC_LO = 16'd12;
  localparam logic [15:0] IDX_SRC_HI = 16'd15;
  localparam logic [15:0] IDX_DST_LO = 16'd16;
  localparam logic [15:0] IDX_DST_HI = 16'd19;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  logic [15:0] cnt_r, cnt_nxt;
  logic [3:0]  ver_r, ver_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [3:0]  toff_r, toff_nxt;
  logic        seen_r, seen_nxt;
  logic [15:0] hoff;

  assign hoff = {10'd0, hw_r, 2'b00};

  always_comb begin
    cnt_nxt   = cnt_r;
    ver_nxt   = ver_r;
    hw_nxt    = hw_r;
    len_nxt   = len_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    toff_nxt  = toff_r;
    seen_nxt  = seen_r;
    push      = 1'b0;
    push_rec  = '0;
    if (byte_fire) begin
      if (cnt_r == 16'd0) begin
        ver_nxt = data_byte[7:4];
        hw_nxt  = data_byte[3:0];
      end else begin
        if (cnt_r == IDX_LEN_HI) len_nxt[15:8] = data_byte;
        if (cnt_r == IDX_LEN_LO) len_nxt[7:0]  = data_byte;
        if (cnt_r == IDX_PROTO)  proto_nxt     = data_byte;
        if (cnt_r >= IDX_SRC_LO && cnt_r <= IDX_SRC_HI) src_nxt = {src_r[23:0], data_byte};
        if (cnt_r >= IDX_DST_LO && cnt_r <= IDX_DST_HI) dst_nxt = {dst_r[23:0], data_byte};
        // Transport fields sit at offsets relative to the IP header length.
        if (cnt_r == hoff)          sport_nxt[15:8] = data_byte;
        if (cnt_r == hoff + 16'd1)  sport_nxt[7:0]  = data_byte;
        if (cnt_r == hoff + 16'd2)  dport_nxt[15:8] = data_byte;
        if (cnt_r == hoff + 16'd3)  dport_nxt[7:0]  = data_byte;
        if (cnt_r == hoff + 16'd12) begin
          toff_nxt = data_byte[7:4];
          seen_nxt = 1'b1;
        end
      end
      if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 16'd1;
      if (last_byte) begin
        push              = 1'b1;
        push_rec.cap_len   = cnt_nxt;
        push_rec.version   = ver_nxt;
        push_rec.hdr_words = hw_nxt;
        push_rec.total_len = len_nxt;
        push_rec.proto     = proto_nxt;
        push_rec.src_addr  = src_nxt;
        push_rec.dst_addr  = dst_nxt;
        push_rec.l4_sport  = sport_nxt;
        push_rec.l4_dport  = dport_nxt;
        push_rec.tcp_off   = toff_nxt;
        push_rec.off_seen  = seen_nxt;
        cnt_nxt   = '0;
        ver_nxt   = '0;
        hw_nxt    = '0;
        len_nxt   = '0;
        proto_nxt = '0;
        src_nxt   = '0;
        dst_nxt   = '0;
        sport_nxt = '0;
        dport_nxt = '0;
        toff_nxt  = '0;
        seen_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ver_r   <= '0;
      hw_r    <= '0;
      len_r   <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
      toff_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      ver_r   <= ver_nxt;
      hw_r    <= hw_nxt;
      len_r   <= len_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      toff_r  <= toff_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// ===== rtl/ipv4ft_queue.sv =====
// Small record queue between the front and back of the extractor.
// Register storage with a combinational head read. Depends on ipv4ft_pkg.
module ipv4ft_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ipv4ft_pkg::pkt_rec_t push_rec,
  input  logic                 pop,
  output ipv4ft_pkg::pkt_rec_t head_rec,
  output ipv4ft_pkg::q_stat_t  stat
);
  import ipv4ft_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pkt_rec_t      mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

// ===== rtl/ipv4ft_back.sv =====
// Back end of the extractor: length and version checks, result formatting
// and the output register. Depends on ipv4ft_pkg.
module ipv4ft_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ipv4ft_pkg::pkt_rec_t             head_rec,
  input  ipv4ft_pkg::q_stat_t              q_stat,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ipv4ft_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ipv4ft_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;
  logic [OUT_TDATA_W-1:0] res;
  logic [6:0]             hlen;
  logic [6:0]             tcp_need;
  logic [6:0]             short_need;
  logic                   bad;
  logic                   has_ports;

  assign hlen       = {1'b0, head_rec.hdr_words, 2'b00};
  assign tcp_need   = hlen + {1'b0, head_rec.tcp_off, 2'b00};
  assign short_need = hlen + L4_SHORT_HDR;
  assign has_ports  = (head_rec.proto == PROTO_TCP) || (head_rec.proto == PROTO_UDP);

  always_comb begin
    bad = 1'b0;
    if (head_rec.version != IP_VERSION4) bad = 1'b1;
    if (head_rec.hdr_words < MIN_IHL) bad = 1'b1;
    if (head_rec.cap_len < 16'(hlen)) bad = 1'b1;
    if (head_rec.proto == PROTO_TCP) begin
      if (!head_rec.off_seen) bad = 1'b1;
      if (head_rec.cap_len < 16'(tcp_need)) bad = 1'b1;
    end else if (head_rec.proto == PROTO_UDP || head_rec.proto == PROTO_ICMP) begin
      if (head_rec.cap_len < 16'(short_need)) bad = 1'b1;
    end
  end

  // An errored word carries only the status bit; everything else is zero.
  always_comb begin
    res = '0;
    if (bad) begin
      res[0] = STATUS_BAD;
    end else begin
      res[0]       = STATUS_OK;
      res[32:1]    = head_rec.src_addr;
      res[64:33]   = head_rec.dst_addr;
      res[72:65]   = head_rec.proto;
      res[88:73]   = has_ports ? head_rec.l4_sport : 16'd0;
      res[104:89]  = has_ports ? head_rec.l4_dport : 16'd0;
      res[120:105] = head_rec.total_len;
    end
  end

  assign pop       = !q_stat.empty && (!valid_r || out_tready);
  assign valid_nxt = pop ? 1'b1 : (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= res;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ===== rtl/ipv4_five_tuple_extractor.sv =====
// Top level of the IPv4 five-tuple extractor: front capture, record queue, back checks.
// Depends on ipv4ft_pkg, ipv4ft_front, ipv4ft_queue and ipv4ft_back.
//
//  Channel | Direction | Word contents
//  --------+-----------+-----------------------------------------------------------
//  in_*    | slave     | one packet byte per word, tlast on the final captured byte
//  out_*   | master    | one result word per packet: status and five-tuple
//
// The input takes one byte every cycle while in_tready is high; each result word is registered
// in the queue, then in the output register, and waits while earlier results are queued.
// in_tready drops only when the QUEUE_DEPTH-entry record queue is full.
// A stalled output holds its word and does not stop byte capture until the queue fills.
// Reset is synchronous and active low; it clears the counter, captured fields and queue.
module ipv4_five_tuple_extractor #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] status, [32:1] src_address, [64:33] dst_address, [72:65] protocol,
  // [88:73] source port, [104:89] destination port, [120:105] total_length,
  // [127:121] zero
  output logic [ipv4ft_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ipv4ft_pkg::*;

  logic     byte_fire;
  logic     push;
  logic     pop;
  pkt_rec_t push_rec;
  pkt_rec_t head_rec;
  q_stat_t  q_stat;

  assign in_tready = !q_stat.full;
  assign byte_fire = in_tvalid && in_tready;

  ipv4ft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push),
    .push_rec  (push_rec)
  );

  ipv4ft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  ipv4ft_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (head_rec),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/ipv4ft_checker.sv =====
// Port-level checks for the IPv4 five-tuple extractor, bound to the top level.
// Depends on ipv4ft_pkg and ipv4_five_tuple_extractor.
module ipv4ft_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ipv4ft_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ipv4ft_pkg::*;

  // A result word is never produced straight out of reset.
  a_no_word_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word shown in the cycle after reset");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // An errored word carries nothing but its status bit.
  a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] == STATUS_BAD |-> out_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("errored result carries non-zero fields");

  a_ports_only_tcp_udp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[72:65] != PROTO_TCP && out_tdata[72:65] != PROTO_UDP
      |-> out_tdata[104:73] == '0)
    else $error("ports set for a protocol without ports");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:121] == '0)
    else $error("padding bits of the result word are set");

endmodule

bind ipv4_five_tuple_extractor ipv4ft_checker u_ipv4ft_checker (.*);
